// ----- hw/rtl/rar_pkg.sv -----
package rar_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned NumWidth = 33;
  localparam int unsigned DenWidth = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;
endpackage

// ----- hw/rtl/rational_arith_reduce.sv -----
// rational_arith_reduce: exact add/subtract/multiply/divide of two signed
// fractions a/b and c/d, with the result reduced by the gcd of its parts.
// Input channel: in_valid_i/in_stall_o with op_i and the four operands; a
// transfer happens on a rising edge with valid high and stall low. Output
// channel: out_valid_o/out_stall_i with result_numerator_o,
// result_denominator_o and error_o; one result per input item.
// One item is handled at a time. Products come from a shift-add multiplier
// (one bit per cycle), the gcd from a binary gcd loop (one step per cycle),
// and the two exact divisions from a restoring divider (one quotient bit per
// cycle). All share a single wide add/subtract/compare unit.
// Add and subtract form three products and combine the first two; multiply
// and divide form two. Then the gcd loop runs, then the numerator and the
// denominator are each divided by the gcd. Error items skip straight to
// the done state.
// The result sits in an output register until taken; in_stall_o stays high
// from transfer in until the result is taken, so the next transfer in comes
// in the cycle after the result transfer at the earliest. Reset clears the
// sequencer and the output valid; no item is in progress afterward.
module rational_arith_reduce #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OperandWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic signed [OPERAND_WIDTH-1:0]  first_numerator_i,
  input  logic signed [OPERAND_WIDTH-1:0]  first_denominator_i,
  input  logic signed [OPERAND_WIDTH-1:0]  second_numerator_i,
  input  logic signed [OPERAND_WIDTH-1:0]  second_denominator_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rar_pkg::NumWidth-1:0] result_numerator_o,
  output logic [rar_pkg::DenWidth-1:0]     result_denominator_o,
  output logic                             error_o
);
  localparam int unsigned W = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;        // product width
  localparam int unsigned VW = PW + 1;       // sum width
  localparam int unsigned CW = $clog2(VW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_COMB, S_DMUL, S_GTZ, S_GCD, S_GFIX,
    S_DIVN, S_DIVD, S_DONE
  } state_e;

  state_e state_q;
  logic [W-1:0] ma_q, mb_q, mc_q, md_q;
  logic sa_q, sb_q, sc_q, sd_q;
  logic [1:0] op_q;
  logic [VW-1:0] acc_q, m1_q, nmag_q, dmag_q, gx_q, gy_q, rem_q, quo_q, dsor_q;
  logic [W-1:0] mplier_q;
  logic [CW-1:0] cnt_q, k_q;
  logic s1_q, nneg_q, dneg_q;
  logic [rar_pkg::NumWidth-1:0] rn_q;
  logic [rar_pkg::DenWidth-1:0] rd_q;
  logic err_q, ovalid_q;

  // shared add/subtract unit
  logic [VW-1:0] alu_a, alu_b, alu_y;
  logic alu_sub, alu_lt;
  logic [VW:0] alu_full;
  always_comb begin
    alu_full = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
    alu_y = alu_full[VW-1:0];
    alu_lt = alu_sub & alu_full[VW];
  end

  function automatic logic [W-1:0] absv(input logic [W-1:0] v);
    absv = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic in_ok;
  assign in_ok = in_valid_i & (state_q == S_IDLE) & ~ovalid_q;
  assign in_stall_o = ~((state_q == S_IDLE) & ~ovalid_q);

  logic [W-1:0] mcand_sel;
  logic [VW-1:0] rem_sh;
  always_comb begin
    mcand_sel = md_q;
    unique case (state_q)
      S_MUL1: mcand_sel = (op_q == rar_pkg::OP_MUL) ? mc_q : md_q;
      S_MUL2: mcand_sel = mb_q;
      S_DMUL: mcand_sel = (op_q == rar_pkg::OP_DIV) ? mc_q : md_q;
      default: mcand_sel = md_q;
    endcase
    rem_sh = {rem_q[VW-2:0], quo_q[VW-1]};
    alu_a = acc_q;
    alu_b = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_MUL1, S_MUL2, S_DMUL: begin
        alu_a = acc_q;
        alu_b = mplier_q[0] ? (VW'(mcand_sel) << cnt_q) : '0;
      end
      S_COMB: begin
        alu_a = m1_q;
        alu_b = acc_q;
        alu_sub = s1_q;
      end
      S_GCD: begin
        alu_a = gx_q;
        alu_b = gy_q;
        alu_sub = 1'b1;
      end
      S_DIVN, S_DIVD: begin
        alu_a = rem_sh;
        alu_b = dsor_q;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
          if (in_ok) begin
            op_q <= op_i;
            sa_q <= first_numerator_i[W-1];
            sb_q <= first_denominator_i[W-1];
            sc_q <= second_numerator_i[W-1];
            sd_q <= second_denominator_i[W-1];
            ma_q <= absv(first_numerator_i);
            mb_q <= absv(first_denominator_i);
            mc_q <= absv(second_numerator_i);
            md_q <= absv(second_denominator_i);
            mplier_q <= absv(first_numerator_i);
            acc_q <= '0;
            cnt_q <= '0;
            if (first_denominator_i == '0 || second_denominator_i == '0 ||
                (op_i == rar_pkg::OP_DIV && second_numerator_i == '0)) begin
              rn_q <= '0;
              rd_q <= '0;
              err_q <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_MUL1;
            end
          end
        end
        // shift-add: multiplicand shifted by the multiplier bit position
        S_MUL1, S_MUL2, S_DMUL: begin
          acc_q <= alu_y;
          mplier_q <= mplier_q >> 1;
          if (cnt_q == CW'(W - 1)) begin
            cnt_q <= '0;
            if (state_q == S_MUL1) begin
              m1_q <= alu_y;
              s1_q <= (op_q == rar_pkg::OP_MUL) ? (sa_q != sc_q) : (sa_q != sd_q);
              if (op_q[1]) begin
                nmag_q <= alu_y;
                nneg_q <= (op_q == rar_pkg::OP_MUL) ? (sa_q != sc_q) : (sa_q != sd_q);
                mplier_q <= mb_q;
                acc_q <= '0;
                state_q <= S_DMUL;
              end else begin
                mplier_q <= mc_q;
                acc_q <= '0;
                state_q <= S_MUL2;
              end
            end else if (state_q == S_MUL2) begin
              // decide numerator sign from s1 and s2
              logic s2, s1e, s2e;
              s2 = (sc_q != sb_q) != (op_q == rar_pkg::OP_SUB);
              s1e = (m1_q == '0) ? s2 : (sa_q != sd_q);
              s2e = (alu_y == '0) ? s1e : s2;
              s1_q <= (s1e != s2e);
              if (s1e == s2e) nneg_q <= s1e;
              else if (m1_q >= alu_y) nneg_q <= s1e;
              else begin
                nneg_q <= s2e;
                m1_q <= alu_y;
                acc_q <= m1_q;
              end
              state_q <= S_COMB;
            end else begin
              dmag_q <= alu_y;
              dneg_q <= (op_q == rar_pkg::OP_DIV) ? (sb_q != sc_q) : (sb_q != sd_q);
              gx_q <= nmag_q;
              gy_q <= alu_y;
              k_q <= '0;
              state_q <= (nmag_q == '0) ? S_GFIX : S_GTZ;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_COMB: begin
          // s1_q flags differing product signs: larger minus smaller
          nmag_q <= alu_y;
          mplier_q <= mb_q;
          acc_q <= '0;
          state_q <= S_DMUL;
        end
        // strip common factors of two
        S_GTZ: begin
          if (!gx_q[0] && !gy_q[0]) begin
            gx_q <= gx_q >> 1;
            gy_q <= gy_q >> 1;
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          if (!gx_q[0]) gx_q <= gx_q >> 1;
          else if (!gy_q[0]) gy_q <= gy_q >> 1;
          else if (gx_q == gy_q) state_q <= S_GFIX;
          else if (alu_lt) gy_q <= (gy_q - gx_q) >> 1;
          else gx_q <= alu_y >> 1;
        end
        S_GFIX: begin
          // gcd = gx << k (the divisor is dmag itself when the numerator is zero)
          dsor_q <= (nmag_q == '0) ? dmag_q : (gx_q << k_q);
          rem_q <= '0;
          quo_q <= nmag_q;
          cnt_q <= '0;
          state_q <= S_DIVN;
        end
        S_DIVN, S_DIVD: begin
          if (alu_lt) begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[VW-2:0], 1'b0};
          end else begin
            rem_q <= alu_y;
            quo_q <= {quo_q[VW-2:0], 1'b1};
          end
          if (cnt_q == CW'(VW - 1)) begin
            cnt_q <= '0;
            if (state_q == S_DIVN) begin
              nmag_q <= {quo_q[VW-2:0], ~alu_lt};
              rem_q <= '0;
              quo_q <= dmag_q;
              state_q <= S_DIVD;
            end else begin
              rn_q <= ((nneg_q != dneg_q) && nmag_q != '0) ?
                      rar_pkg::NumWidth'(~nmag_q + 1'b1) : rar_pkg::NumWidth'(nmag_q);
              rd_q <= rar_pkg::DenWidth'({quo_q[VW-2:0], ~alu_lt});
              err_q <= 1'b0;
              state_q <= S_DONE;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DONE: begin
          ovalid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign result_numerator_o = rn_q;
  assign result_denominator_o = rd_q;
  assign error_o = err_q;
endmodule
